FILE: sv/gcdl_pkg.sv
package gcdl_pkg;

  localparam int UPC_W = 3;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_HALVE = 3'd1,
    OP_STEIN = 3'd2,
    OP_FIN   = 3'd3,
    OP_DIV   = 3'd4,
    OP_MUL   = 3'd5,
    OP_ZERO  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_GOTO      = 3'd1,
    COND_ZERO_OPND = 3'd2,
    COND_BOTH_EVEN = 3'd3,
    COND_B_NZ      = 3'd4,
    COND_CNT_NLAST = 3'd5,
    COND_OUT_FREE  = 3'd6
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic zero_opnd;
    logic both_even;
    logic b_nz;
    logic cnt_last;
  } stat_t;

  localparam logic [UPC_W-1:0] UPC_CHECK = 3'd0;
  localparam logic [UPC_W-1:0] UPC_HALVE = 3'd1;
  localparam logic [UPC_W-1:0] UPC_STEIN = 3'd2;
  localparam logic [UPC_W-1:0] UPC_FIN   = 3'd3;
  localparam logic [UPC_W-1:0] UPC_DIV   = 3'd4;
  localparam logic [UPC_W-1:0] UPC_MUL   = 3'd5;
  localparam logic [UPC_W-1:0] UPC_ZERO  = 3'd6;
  localparam logic [UPC_W-1:0] UPC_DONE  = 3'd7;

  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucw_t w;
    w = '{op: OP_NOP, cond: COND_NEXT, target: UPC_CHECK};
    unique case (upc)
      UPC_CHECK: w = '{op: OP_NOP,   cond: COND_ZERO_OPND, target: UPC_ZERO};
      UPC_HALVE: w = '{op: OP_HALVE, cond: COND_BOTH_EVEN, target: UPC_HALVE};
      UPC_STEIN: w = '{op: OP_STEIN, cond: COND_B_NZ,      target: UPC_STEIN};
      UPC_FIN:   w = '{op: OP_FIN,   cond: COND_NEXT,      target: UPC_CHECK};
      UPC_DIV:   w = '{op: OP_DIV,   cond: COND_CNT_NLAST, target: UPC_DIV};
      UPC_MUL:   w = '{op: OP_MUL,   cond: COND_GOTO,      target: UPC_DONE};
      UPC_ZERO:  w = '{op: OP_ZERO,  cond: COND_NEXT,      target: UPC_CHECK};
      UPC_DONE:  w = '{op: OP_NOP,   cond: COND_OUT_FREE,  target: UPC_DONE};
      default:   w = '{op: OP_NOP,   cond: COND_NEXT,      target: UPC_CHECK};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/gcd_lcm_unit_core.sv
// Channel  Ports                                          Direction
// in       in_valid, in_ready, in_operand_x, in_operand_y  word in
// out      out_valid, out_ready, out_gcd_value,            word out
//          out_lcm_value, out_invalid
//
// One word is worked on at a time. With W = OPERAND_WIDTH, a word with both
// operands nonzero runs the halving and subtraction steps of the binary GCD
// loop and then the one-bit-per-cycle restoring divider for the W-bit
// quotient; a word with a zero operand skips both.
// Reset clears the sequencer and the output valid; the result register lets
// a new word be accepted while the previous result waits for out_ready.
module gcd_lcm_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_x,
  input  logic [31:0] in_operand_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_gcd_value,
  output logic [62:0] out_lcm_value,
  output logic        out_invalid
);

  localparam int W = OPERAND_WIDTH;

  gcdl_pkg::ctrl_t ctrl;
  gcdl_pkg::stat_t stat;
  logic            busy, start, out_free;
  logic [W-1:0]    gcd_raw;
  logic [2*W-1:0]  lcm_mag;
  logic            lcm_neg, both_zero;
  logic [31:0]     gcd_ext;
  logic [63:0]     lcm_ext, lcm_signed;

  logic        out_valid_r, out_valid_nxt;
  logic [30:0] gcd_r, gcd_nxt;
  logic [62:0] lcm_r, lcm_nxt;
  logic        inv_r, inv_nxt;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  gcdl_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  gcdl_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk          (clk),
    .ctrl         (ctrl),
    .in_operand_x (in_operand_x),
    .in_operand_y (in_operand_y),
    .stat         (stat),
    .gcd_raw      (gcd_raw),
    .lcm_mag      (lcm_mag),
    .lcm_neg      (lcm_neg),
    .both_zero    (both_zero)
  );

  assign gcd_ext    = 32'(gcd_raw);
  assign lcm_ext    = 64'(lcm_mag);
  assign lcm_signed = lcm_neg ? (~lcm_ext + 1'b1) : lcm_ext;

  always_comb begin
    out_valid_nxt = out_valid_r;
    gcd_nxt       = gcd_r;
    lcm_nxt       = lcm_r;
    inv_nxt       = inv_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
      gcd_nxt       = gcd_ext[31] ? '1 : gcd_ext[30:0];
      lcm_nxt       = lcm_signed[62:0];
      inv_nxt       = both_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gcd_r <= gcd_nxt;
    lcm_r <= lcm_nxt;
    inv_r <= inv_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_gcd_value = gcd_r;
  assign out_lcm_value = lcm_r;
  assign out_invalid   = inv_r;

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_gcd_value == '0 && out_lcm_value == '0)
    else $error("invalid result carries nonzero values");

  a_gcd_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> out_gcd_value != '0)
    else $error("valid operands gave a zero gcd");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("input taken while a word is in progress");

  a_emit_free : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> busy && out_free)
    else $error("result written over a pending word");

endmodule

FILE: sv/gcdl_useq.sv
module gcdl_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gcdl_pkg::stat_t     stat,
  input  logic                out_free,
  output gcdl_pkg::ctrl_t     ctrl,
  output logic                busy
);

  logic [gcdl_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic                       busy_r, busy_nxt;
  gcdl_pkg::ucw_t             ucw;
  logic                       take;

  assign ucw = gcdl_pkg::ucode_rom(upc_r);

  always_comb begin
    take = 1'b0;
    case (ucw.cond)
      gcdl_pkg::COND_GOTO:      take = 1'b1;
      gcdl_pkg::COND_ZERO_OPND: take = stat.zero_opnd;
      gcdl_pkg::COND_BOTH_EVEN: take = stat.both_even;
      gcdl_pkg::COND_B_NZ:      take = stat.b_nz;
      gcdl_pkg::COND_CNT_NLAST: take = !stat.cnt_last;
      gcdl_pkg::COND_OUT_FREE:  take = !out_free;
      default:                  take = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = gcdl_pkg::UPC_CHECK;
      end
    end else if (ucw.cond == gcdl_pkg::COND_OUT_FREE && out_free) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      upc_nxt = ucw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= gcdl_pkg::UPC_CHECK;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy      = busy_r;
  assign ctrl.load = start && !busy_r;
  assign ctrl.op   = busy_r ? ucw.op : gcdl_pkg::OP_NOP;
  assign ctrl.emit = busy_r && (ucw.cond == gcdl_pkg::COND_OUT_FREE) && out_free;

endmodule

FILE: sv/gcdl_dp.sv
module gcdl_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                       clk,
  input  gcdl_pkg::ctrl_t            ctrl,
  input  logic [31:0]                in_operand_x,
  input  logic [31:0]                in_operand_y,
  output gcdl_pkg::stat_t            stat,
  output logic [OPERAND_WIDTH-1:0]   gcd_raw,
  output logic [2*OPERAND_WIDTH-1:0] lcm_mag,
  output logic                       lcm_neg,
  output logic                       both_zero
);

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(W);

  logic [W-1:0]   xw, yw, ax, ay;
  logic [W-1:0]   a_r, a_nxt, b_r, b_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  logic [W-1:0]   q_r, q_nxt, rem_r, rem_nxt;
  logic [KW-1:0]  k_r, k_nxt, cnt_r, cnt_nxt;
  logic [2*W-1:0] prod_r, prod_nxt;
  logic           neg_r, neg_nxt, inv_r, inv_nxt;
  logic [W:0]     diff_ab, diff_ba, trial, trial_sub;

  assign xw = in_operand_x[W-1:0];
  assign yw = in_operand_y[W-1:0];
  assign ax = xw[W-1] ? (~xw + 1'b1) : xw;
  assign ay = yw[W-1] ? (~yw + 1'b1) : yw;

  assign diff_ab   = {1'b0, a_r} - {1'b0, b_r};
  assign diff_ba   = {1'b0, b_r} - {1'b0, a_r};
  assign trial     = {rem_r, q_r[W-1]};
  assign trial_sub = trial - {1'b0, a_r};

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    ax_nxt   = ax_r;
    ay_nxt   = ay_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    inv_nxt  = inv_r;
    if (ctrl.load) begin
      a_nxt   = ax;
      b_nxt   = ay;
      ax_nxt  = ax;
      ay_nxt  = ay;
      k_nxt   = '0;
      neg_nxt = xw[W-1] ^ yw[W-1];
      inv_nxt = (ax == '0) && (ay == '0);
    end else begin
      unique case (ctrl.op)
        gcdl_pkg::OP_NOP: begin
        end
        gcdl_pkg::OP_HALVE: begin
          if (!a_r[0] && !b_r[0]) begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
            k_nxt = k_r + 1'b1;
          end
        end
        gcdl_pkg::OP_STEIN: begin
          if (!a_r[0]) begin
            a_nxt = a_r >> 1;
          end else if (!b_r[0]) begin
            b_nxt = b_r >> 1;
          end else if (diff_ba[W]) begin
            a_nxt = b_r;
            b_nxt = diff_ab[W-1:0];
          end else begin
            b_nxt = diff_ba[W-1:0];
          end
        end
        gcdl_pkg::OP_FIN: begin
          a_nxt   = a_r << k_r;
          q_nxt   = ax_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
        gcdl_pkg::OP_DIV: begin
          if (!trial_sub[W]) begin
            rem_nxt = trial_sub[W-1:0];
            q_nxt   = {q_r[W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[W-1:0];
            q_nxt   = {q_r[W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 1'b1;
        end
        gcdl_pkg::OP_MUL: begin
          prod_nxt = (2*W)'(q_r) * (2*W)'(ay_r);
        end
        gcdl_pkg::OP_ZERO: begin
          a_nxt    = ax_r | ay_r;
          prod_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    inv_r  <= inv_nxt;
  end

  assign stat.zero_opnd = (ax_r == '0) || (ay_r == '0);
  assign stat.both_even = !a_r[0] && !b_r[0];
  assign stat.b_nz      = (b_r != '0);
  assign stat.cnt_last  = (cnt_r == KW'(W - 1));

  assign gcd_raw   = a_r;
  assign lcm_mag   = prod_r;
  assign lcm_neg   = neg_r;
  assign both_zero = inv_r;

endmodule
